[rtl/jih_pkg.sv]
// Package for the joint intensity histogram.
// Holds command and state codes, register indexes and field widths.
// No dependencies.
package jih_pkg;

  localparam int unsigned VALUE_W = 8;
  localparam int unsigned INDEX_W = 12;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned DIV_W   = 8;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned IN_W    = 32;

  localparam logic [COUNT_W-1:0] COUNT_INCR = 32'd2;
  localparam logic [COUNT_W-1:0] COUNT_SAT  = 32'hFFFF_FFFD;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ACC   = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_RUN   = 2'd1,
    ST_DIV   = 2'd2
  } state_e;

  localparam logic REG_LOG2_BINS = 1'b0;
  localparam logic REG_BG_DIV    = 1'b1;

endpackage

[rtl/joint_intensity_histogram.sv]
// Top level of the joint intensity histogram: bin store, accumulate pipeline and divider.
// Depends on jih_pkg.
//
// Builds a 2D histogram of paired 8-bit grey values. A new accumulate word is taken every
// cycle while the block runs and no read is pending: the bin is read from a
// single-port-write memory, incremented by two with saturation and written back in the
// next cycle, with forwarding from the last write. A read word holds off further input
// until its result is loaded; a background-row read with a nonzero divisor
// runs a one-bit-per-cycle restoring divider. Reset and a clear word sweep all
// 2^(2*floor(log2(MAX_BINS))) bins (4096 at the default), one per cycle, taking no word.
// Configuration writes are taken at any time and must only be made when the block is idle.
module joint_intensity_histogram import jih_pkg::*; #(
  parameter int unsigned MAX_BINS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // command[1:0], target_value[9:2], render_value[17:10], bin_index[29:18], zero fill
  input  logic [IN_W-1:0]    s_axis_tdata,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // bin_count[31:0]
  output logic [COUNT_W-1:0] m_axis_tdata,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [DIV_W-1:0]   cfg_data_i
);

  localparam int unsigned CAP   = $clog2(MAX_BINS + 1) - 1;
  localparam int unsigned AW    = 2 * CAP;
  localparam int unsigned DEPTH = 1 << AW;
  localparam logic [3:0]  CapS  = 4'(CAP);

  logic [COUNT_W-1:0] mem [DEPTH];

  state_e state_q, state_d;

  logic [2:0]         log2_bins_q;
  logic [DIV_W-1:0]   bg_div_q;

  logic [1:0]         in_cmd;
  logic [VALUE_W-1:0] in_tv, in_rv;
  logic [INDEX_W-1:0] in_idx;
  logic               in_fire;

  logic [3:0]         s_eff, k_sh;
  logic [VALUE_W-1:0] a_bin, b_bin;
  logic [15:0]        pos16, idx16;
  logic [16:0]        lim_all, lim_bg;
  logic [AW-1:0]      raddr;

  logic               s1_acc_q, s1_read_q;
  logic               s1_inrange_q, s1_bg_q;
  logic [AW-1:0]      s1_addr_q;
  logic [COUNT_W-1:0] rdata_q;

  logic               wr_valid_q, wr_valid_d;
  logic [AW-1:0]      wr_addr_q;
  logic [COUNT_W-1:0] wr_data_q;

  logic [COUNT_W-1:0] operand, acc_new;
  logic               read_go, read_div;
  logic [COUNT_W-1:0] read_val;

  logic [AW-1:0]      clr_addr_q;
  logic               clr_last;

  logic [COUNT_W-1:0] quo_q;
  logic [DIV_W-1:0]   rem_q;
  logic [4:0]         cnt_q;
  logic [DIV_W:0]     rem_shift;
  logic               q_bit;
  logic [DIV_W-1:0]   rem_next;
  logic               div_done;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [COUNT_W-1:0] mem_wdata;

  logic               out_valid_q, out_valid_d, out_load;
  logic [COUNT_W-1:0] out_data_q, out_data_in;

  // Input fields
  assign in_cmd  = s_axis_tdata[1:0];
  assign in_tv   = s_axis_tdata[9:2];
  assign in_rv   = s_axis_tdata[17:10];
  assign in_idx  = s_axis_tdata[29:18];
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // Bin geometry
  always_comb begin
    priority if (log2_bins_q == 3'd0) begin
      s_eff = 4'd1;
    end else if ({1'b0, log2_bins_q} > CapS) begin
      s_eff = CapS;
    end else begin
      s_eff = {1'b0, log2_bins_q};
    end
    k_sh    = 4'd8 - s_eff;
    a_bin   = in_tv >> k_sh;
    b_bin   = in_rv >> k_sh;
    pos16   = {8'b0, a_bin} | ({8'b0, b_bin} << s_eff);
    idx16   = {4'b0, in_idx};
    lim_all = 17'd1 << {s_eff, 1'b0};
    lim_bg  = 17'd1 << s_eff;
    raddr   = (in_cmd == CMD_ACC) ? pos16[AW-1:0] : idx16[AW-1:0];
  end

  // Read-modify-write
  assign operand  = (wr_valid_q && (wr_addr_q == s1_addr_q)) ? wr_data_q : rdata_q;
  assign acc_new  = (operand > COUNT_SAT) ? '1 : operand + COUNT_INCR;
  assign read_go  = s1_read_q && (!out_valid_q || m_axis_tready);
  assign read_div = s1_inrange_q && s1_bg_q && (bg_div_q != '0);

  always_comb begin
    priority if (!s1_inrange_q) begin
      read_val = '0;
    end else if (s1_bg_q) begin
      read_val = '0;
    end else begin
      read_val = operand;
    end
  end

  // Restoring divider step
  assign rem_shift = {rem_q, quo_q[COUNT_W-1]};
  assign q_bit     = (rem_shift >= {1'b0, bg_div_q});
  assign rem_next  = q_bit ? DIV_W'(rem_shift - {1'b0, bg_div_q}) : rem_shift[DIV_W-1:0];
  assign div_done  = (state_q == ST_DIV) && (cnt_q == 5'd0);

  assign clr_last = (clr_addr_q == '1);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_last) state_d = ST_RUN;
      ST_RUN: begin
        priority if (in_fire && (in_cmd == CMD_CLEAR)) begin
          state_d = ST_CLEAR;
        end else if (read_go && read_div) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: if (div_done) state_d = ST_RUN;
      default: state_d = ST_CLEAR;
    endcase
  end

  // State outputs
  always_comb begin
    s_axis_tready = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = s1_addr_q;
    mem_wdata     = acc_new;
    wr_valid_d    = wr_valid_q;
    out_load      = 1'b0;
    out_data_in   = read_val;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we     = 1'b1;
        mem_waddr  = clr_addr_q;
        mem_wdata  = '0;
        wr_valid_d = 1'b0;
      end
      ST_RUN: begin
        s_axis_tready = !s1_read_q;
        mem_we        = s1_acc_q;
        if (s1_acc_q) wr_valid_d = 1'b1;
        out_load      = read_go && !read_div;
      end
      ST_DIV: begin
        out_load    = div_done;
        out_data_in = {quo_q[COUNT_W-2:0], q_bit};
      end
      default: ;
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_valid_q && !m_axis_tready);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      log2_bins_q <= 3'd4;
      bg_div_q    <= 8'd2;
      s1_acc_q    <= 1'b0;
      s1_read_q   <= 1'b0;
      wr_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      wr_valid_q  <= wr_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_LOG2_BINS: log2_bins_q <= cfg_data_i[2:0];
          REG_BG_DIV:    bg_div_q    <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_CLEAR) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end else if (in_fire && (in_cmd == CMD_CLEAR)) begin
        clr_addr_q <= '0;
      end
      if (in_fire) begin
        s1_acc_q  <= (in_cmd == CMD_ACC);
        s1_read_q <= (in_cmd == CMD_READ);
      end else begin
        s1_acc_q <= 1'b0;
        if (read_go) s1_read_q <= 1'b0;
      end
      if (state_q == ST_DIV) begin
        cnt_q <= cnt_q - 5'd1;
      end else if (read_go) begin
        cnt_q <= 5'd31;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_addr_q    <= raddr;
      s1_inrange_q <= ({1'b0, idx16} < lim_all);
      s1_bg_q      <= ({1'b0, idx16} < lim_bg);
    end
    if (s1_acc_q && (state_q == ST_RUN)) begin
      wr_addr_q <= s1_addr_q;
      wr_data_q <= acc_new;
    end
    if (state_q == ST_DIV) begin
      quo_q <= {quo_q[COUNT_W-2:0], q_bit};
      rem_q <= rem_next;
    end else if (read_go) begin
      quo_q <= operand;
      rem_q <= '0;
    end
    if (out_load) out_data_q <= out_data_in;
  end

  // Bin store
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (in_fire) rdata_q <= mem[raddr];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

[rtl/jih_checker.sv]
// Port-level checker for the joint intensity histogram, bound to the top level.
// Depends on jih_pkg and joint_intensity_histogram.
module jih_checker import jih_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic [IN_W-1:0]    s_axis_tdata,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [COUNT_W-1:0] m_axis_tdata
);

  logic s_fire;
  assign s_fire = s_axis_tvalid && s_axis_tready;

  a_read_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && (s_axis_tdata[1:0] == CMD_READ)) |=> !s_axis_tready)
    else $error("input taken in the cycle after a read word");

  a_clear_sweeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && (s_axis_tdata[1:0] == CMD_CLEAR)) |=> !s_axis_tready)
    else $error("input taken in the cycle after a clear word");

  a_acc_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && (s_axis_tdata[1:0] == CMD_ACC) && !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("result word without a read");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result word changed");

endmodule

bind joint_intensity_histogram jih_checker u_jih_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
